/* hdl/tgff_pkg.sv */
// Package for the tile grid flood fill block: operation and status codes,
// tile id width and the empty tile pattern.
// No dependencies.
package tgff_pkg;

  localparam int ID_W  = 13;
  localparam int CFG_W = 7;

  localparam logic [ID_W-1:0] EMPTY_ID = '1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FILL  = 2'd2,
    KIND_FLOOD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_SAME    = 2'd2
  } status_t;

  typedef enum logic {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

/* hdl/tile_grid_flood_fill.sv */
// Top level of the tile grid flood fill block: grid memory, pending-cell stack
// memory and the sequencer that runs write, read, fill and flood fill.
// Depends on tgff_pkg.

// After reset the block first clears the grid to empty, one cell per cycle;
// configuration writes are taken during that pass but no transaction is
// accepted. One transaction is worked on at a time, and the next one is
// accepted while an earlier result still waits in the output register. A
// write or a read first makes its grid access, whose read data is registered,
// and then loads the output register. Fill all writes the tile id to every
// cell of the configured map area, one cell write per cycle. A flood fill
// reads each popped cell from the stack and then from the grid; each
// recolored cell visits its four neighbors in turn, since the stack memory
// has a single write port, and pushes those that lie inside the map.
module tile_grid_flood_fill #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [tgff_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic signed [7:0]           in_x,
  input  logic signed [7:0]           in_y,
  input  logic signed [tgff_pkg::ID_W-1:0] in_tile_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [tgff_pkg::ID_W-1:0] out_tile_value,
  output logic [1:0]                  out_status
);

  localparam int CELL_COUNT  = MAX_WIDTH * MAX_HEIGHT;
  localparam int STACK_DEPTH = 4 * CELL_COUNT;
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DWC = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int DW = (DWC > tgff_pkg::CFG_W) ? DWC : tgff_pkg::CFG_W;
  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int SW = XW + YW;
  localparam int KW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = tgff_pkg::ID_W;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RESULT,
    S_FILL,
    S_SEED,
    S_POP,
    S_POPW,
    S_CHECK,
    S_PUSH
  } state_t;

  logic [IW-1:0] grid_mem [CELL_COUNT];
  logic [SW-1:0] stack_mem [STACK_DEPTH];

  state_t                   state_r, state_nxt;
  logic [tgff_pkg::CFG_W-1:0] map_width_r, map_height_r;
  logic [AW-1:0]            clr_r, clr_nxt;
  logic [XW-1:0]            cur_x_r, cur_x_nxt;
  logic [YW-1:0]            cur_y_r, cur_y_nxt;
  logic [IW-1:0]            tid_r, tid_nxt;
  logic [IW-1:0]            orig_r, orig_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [1:0]               dir_r, dir_nxt;
  logic                     from_mem_r, from_mem_nxt;
  logic [IW-1:0]            res_value_r, res_value_nxt;
  logic [1:0]               res_status_r, res_status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [IW-1:0]            out_value_r, out_value_nxt;
  logic [1:0]               out_status_r, out_status_nxt;

  logic                     g_we, g_re;
  logic [AW-1:0]            g_waddr, g_raddr;
  logic [IW-1:0]            g_wdata, grid_rd_r;
  logic                     s_we, s_re;
  logic [KW-1:0]            s_waddr, s_raddr;
  logic [SW-1:0]            s_wdata, stack_rd_r;

  logic [DW-1:0]            act_w, act_h, in_x_ext, in_y_ext, cur_x_ext, cur_y_ext;
  logic                     in_inside, in_acc;
  logic [CW-1:0]            cnt_dec;
  logic [XW-1:0]            pop_x;
  logic [YW-1:0]            pop_y;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] cx,
                                               input logic [YW-1:0] cy);
    return AW'(AW'(cy) * AW'(MAX_WIDTH)) + AW'(cx);
  endfunction

  assign act_w = (DW'(map_width_r) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(map_width_r);
  assign act_h = (DW'(map_height_r) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(map_height_r);
  assign in_x_ext  = DW'(in_x[6:0]);
  assign in_y_ext  = DW'(in_y[6:0]);
  assign cur_x_ext = DW'(cur_x_r);
  assign cur_y_ext = DW'(cur_y_r);
  assign in_inside = !in_x[7] && !in_y[7] && (in_x_ext < act_w) && (in_y_ext < act_h);
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cnt_dec   = cnt_r - CW'(1);
  assign pop_x     = stack_rd_r[XW-1:0];
  assign pop_y     = stack_rd_r[SW-1:XW];

  assign out_valid      = out_valid_r;
  assign out_tile_value = out_value_r;
  assign out_status     = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    tid_nxt        = tid_r;
    orig_nxt       = orig_r;
    cnt_nxt        = cnt_r;
    dir_nxt        = dir_r;
    from_mem_nxt   = from_mem_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    g_we    = 1'b0;
    g_waddr = '0;
    g_wdata = '0;
    g_re    = 1'b0;
    g_raddr = '0;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_re    = 1'b0;
    s_raddr = '0;

    case (state_r)
      S_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_r;
        g_wdata = tgff_pkg::EMPTY_ID;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          tid_nxt        = in_tile_id;
          cur_x_nxt      = in_x_ext[XW-1:0];
          cur_y_nxt      = in_y_ext[YW-1:0];
          from_mem_nxt   = 1'b0;
          res_value_nxt  = tgff_pkg::EMPTY_ID;
          res_status_nxt = tgff_pkg::ST_DONE;
          state_nxt      = S_RESULT;
          case (tgff_pkg::kind_t'(in_kind))
            tgff_pkg::KIND_WRITE: begin
              if (in_inside) begin
                g_we    = 1'b1;
                g_waddr = cell_addr(in_x_ext[XW-1:0], in_y_ext[YW-1:0]);
                g_wdata = in_tile_id;
              end else begin
                res_status_nxt = tgff_pkg::ST_OUTSIDE;
              end
            end
            tgff_pkg::KIND_READ: begin
              if (in_inside) begin
                g_re         = 1'b1;
                g_raddr      = cell_addr(in_x_ext[XW-1:0], in_y_ext[YW-1:0]);
                from_mem_nxt = 1'b1;
              end else begin
                res_status_nxt = tgff_pkg::ST_OUTSIDE;
              end
            end
            tgff_pkg::KIND_FILL: begin
              cur_x_nxt = '0;
              cur_y_nxt = '0;
              if (act_w != '0 && act_h != '0) begin
                state_nxt = S_FILL;
              end
            end
            default: begin
              if (in_inside) begin
                g_re      = 1'b1;
                g_raddr   = cell_addr(in_x_ext[XW-1:0], in_y_ext[YW-1:0]);
                state_nxt = S_SEED;
              end else begin
                res_status_nxt = tgff_pkg::ST_OUTSIDE;
              end
            end
          endcase
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = from_mem_r ? grid_rd_r : res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      S_FILL: begin
        g_we    = 1'b1;
        g_waddr = cell_addr(cur_x_r, cur_y_r);
        g_wdata = tid_r;
        if (cur_x_ext + DW'(1) == act_w) begin
          cur_x_nxt = '0;
          cur_y_nxt = cur_y_r + YW'(1);
          if (cur_y_ext + DW'(1) == act_h) begin
            state_nxt = S_RESULT;
          end
        end else begin
          cur_x_nxt = cur_x_r + XW'(1);
        end
      end
      S_SEED: begin
        if (grid_rd_r == tid_r) begin
          res_status_nxt = tgff_pkg::ST_SAME;
          state_nxt      = S_RESULT;
        end else begin
          orig_nxt  = grid_rd_r;
          s_we      = 1'b1;
          s_waddr   = '0;
          s_wdata   = {cur_y_r, cur_x_r};
          cnt_nxt   = CW'(1);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (cnt_r == '0) begin
          state_nxt = S_RESULT;
        end else begin
          s_re      = 1'b1;
          s_raddr   = cnt_dec[KW-1:0];
          cnt_nxt   = cnt_dec;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cur_x_nxt = pop_x;
        cur_y_nxt = pop_y;
        g_re      = 1'b1;
        g_raddr   = cell_addr(pop_x, pop_y);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (grid_rd_r != orig_r) begin
          state_nxt = S_POP;
        end else begin
          g_we      = 1'b1;
          g_waddr   = cell_addr(cur_x_r, cur_y_r);
          g_wdata   = tid_r;
          dir_nxt   = 2'd0;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        s_waddr = cnt_r[KW-1:0];
        case (dir_r)
          2'd0: begin
            s_we    = (cur_x_ext + DW'(1) < act_w);
            s_wdata = {cur_y_r, cur_x_r + XW'(1)};
          end
          2'd1: begin
            s_we    = (cur_x_r != '0);
            s_wdata = {cur_y_r, cur_x_r - XW'(1)};
          end
          2'd2: begin
            s_we    = (cur_y_ext + DW'(1) < act_h);
            s_wdata = {cur_y_r + YW'(1), cur_x_r};
          end
          default: begin
            s_we    = (cur_y_r != '0);
            s_wdata = {cur_y_r - YW'(1), cur_x_r};
          end
        endcase
        if (cnt_r == CW'(STACK_DEPTH)) begin
          s_we = 1'b0;
        end
        if (s_we) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        dir_nxt = dir_r + 2'd1;
        if (dir_r == 2'd3) begin
          state_nxt = S_POP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_waddr] <= g_wdata;
    end
    if (g_re) begin
      grid_rd_r <= grid_mem[g_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      stack_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      stack_rd_r <= stack_mem[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      map_width_r  <= tgff_pkg::CFG_W'(10);
      map_height_r <= tgff_pkg::CFG_W'(10);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (tgff_pkg::reg_idx_t'(cfg_index))
          tgff_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_wdata;
          tgff_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_wdata;
          default: begin
            map_width_r <= map_width_r;
          end
        endcase
      end
    end
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    tid_r        <= tid_nxt;
    orig_r       <= orig_nxt;
    dir_r        <= dir_nxt;
    from_mem_r   <= from_mem_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
